### rtl/core/slfr_pkg.sv
// Package for the sync/length framed byte receiver.
// Frame geometry, sync codes, parser states and the parser-to-emitter burst request.
// No dependencies.
package slfr_pkg;

  // Frame buffer geometry
  localparam int FrameBytes = 64;
  localparam int AddrW      = $clog2(FrameBytes);
  localparam int CountW     = $clog2(FrameBytes + 1);

  // Fixed field widths
  localparam int ByteW = 8;
  localparam int PosW  = 6;
  localparam int ExpW  = 9;

  // Header codes
  localparam logic [ByteW-1:0] SyncFirst  = 8'h5A;
  localparam logic [ByteW-1:0] SyncSecond = 8'hA5;
  localparam logic [ExpW-1:0]  HeaderLen  = 9'd3;

  // Input opcodes
  localparam logic OpByte  = 1'b0;
  localparam logic OpReset = 1'b1;

  // Parser states
  typedef enum logic {
    StRecv,
    StBurst
  } parse_state_e;

  // Burst request from the parser to the emitter
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] len;
  } burst_req_t;

endpackage

### rtl/core/slfr_frame_ram.sv
// Frame buffer: one write port, one registered read port.
// Depends on slfr_pkg for the depth and widths.
module slfr_frame_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [slfr_pkg::AddrW-1:0]  waddr_i,
  input  logic [slfr_pkg::ByteW-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [slfr_pkg::AddrW-1:0]  raddr_i,
  output logic [slfr_pkg::ByteW-1:0]  rdata_o
);

  logic [slfr_pkg::ByteW-1:0] mem [slfr_pkg::FrameBytes];
  logic [slfr_pkg::ByteW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/slfr_parser.sv
// Header hunt, fill count and expected length; writes received bytes to the frame buffer.
// Depends on slfr_pkg; hands completed frames to the emitter as a burst request.
module slfr_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [slfr_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                        emit_busy_i,
  output logic                        we_o,
  output logic [slfr_pkg::AddrW-1:0]  waddr_o,
  output logic [slfr_pkg::ByteW-1:0]  wdata_o,
  output slfr_pkg::burst_req_t        burst_o
);

  slfr_pkg::parse_state_e state_q, state_d;

  logic [slfr_pkg::CountW-1:0] fill_q, fill_d;
  logic [slfr_pkg::ExpW-1:0]   exp_q, exp_d;

  logic                        accept;
  logic                        store;
  logic                        complete;
  logic [slfr_pkg::CountW-1:0] fill_new;
  logic [slfr_pkg::ExpW-1:0]   exp_new;

  assign accept = in_valid_i && in_ready_o;

  // byte classification
  always_comb begin
    store    = 1'b0;
    fill_new = fill_q + slfr_pkg::CountW'(1);
    exp_new  = exp_q;
    if (accept && opcode_i == slfr_pkg::OpByte) begin
      if (fill_q == slfr_pkg::CountW'(0)) begin
        store = (rx_byte_i == slfr_pkg::SyncFirst);
      end else if (fill_q == slfr_pkg::CountW'(1)) begin
        store = (rx_byte_i == slfr_pkg::SyncSecond);
      end else begin
        store = 1'b1;
      end
    end
    // length byte lands at the third slot
    if (slfr_pkg::ExpW'(fill_new) == slfr_pkg::HeaderLen) begin
      exp_new = slfr_pkg::ExpW'(rx_byte_i) + slfr_pkg::HeaderLen;
    end
  end

  assign complete = store && (exp_new != slfr_pkg::ExpW'(0)) &&
                    (slfr_pkg::ExpW'(fill_new) >= exp_new);

  // fill count and expected length
  always_comb begin
    fill_d = fill_q;
    exp_d  = exp_q;
    if (accept) begin
      if (opcode_i == slfr_pkg::OpReset) begin
        fill_d = '0;
        exp_d  = '0;
      end else if (store) begin
        if (complete || fill_new >= slfr_pkg::CountW'(slfr_pkg::FrameBytes)) begin
          // frame done, or buffer full without completing: re-arm
          fill_d = '0;
          exp_d  = '0;
        end else begin
          fill_d = fill_new;
          exp_d  = exp_new;
        end
      end else if (fill_q == slfr_pkg::CountW'(1)) begin
        // bad second sync byte restarts the hunt
        fill_d = '0;
        exp_d  = '0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slfr_pkg::StRecv:  if (complete) state_d = slfr_pkg::StBurst;
      slfr_pkg::StBurst: if (!emit_busy_i) state_d = slfr_pkg::StRecv;
      default:           state_d = slfr_pkg::StRecv;
    endcase
  end

  // outputs; no input is taken during a burst so buffer reads and writes never meet
  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      slfr_pkg::StRecv:  in_ready_o = 1'b1;
      slfr_pkg::StBurst: in_ready_o = 1'b0;
      default:           in_ready_o = 1'b0;
    endcase
  end

  assign we_o          = store;
  assign waddr_o       = fill_q[slfr_pkg::AddrW-1:0];
  assign wdata_o       = rx_byte_i;
  assign burst_o.start = complete;
  assign burst_o.len   = fill_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slfr_pkg::StRecv;
      fill_q  <= '0;
      exp_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      exp_q   <= exp_d;
    end
  end

endmodule

### rtl/core/slfr_emitter.sv
// Burst reader: walks the frame buffer and drives the output word with position and last.
// Depends on slfr_pkg; the byte itself comes from the frame buffer's read register.
module slfr_emitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slfr_pkg::burst_req_t        burst_i,
  output logic                        busy_o,
  output logic                        re_o,
  output logic [slfr_pkg::AddrW-1:0]  raddr_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slfr_pkg::PosW-1:0]   byte_position_o,
  output logic                        last_o
);

  logic                        busy_q, busy_d;
  logic                        valid_q, valid_d;
  logic [slfr_pkg::CountW-1:0] ptr_q, ptr_d;
  logic [slfr_pkg::CountW-1:0] len_q, len_d;
  logic [slfr_pkg::PosW-1:0]   pos_q, pos_d;
  logic                        last_q, last_d;

  logic issue;
  logic is_last;

  // read when the output word is free or leaving this cycle
  assign issue   = busy_q && (!valid_q || out_ready_i);
  assign is_last = (ptr_q + slfr_pkg::CountW'(1)) == len_q;

  always_comb begin
    busy_d  = busy_q;
    ptr_d   = ptr_q;
    len_d   = len_q;
    pos_d   = pos_q;
    last_d  = last_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (burst_i.start) begin
      busy_d = 1'b1;
      ptr_d  = '0;
      len_d  = burst_i.len;
    end else if (issue) begin
      ptr_d   = ptr_q + slfr_pkg::CountW'(1);
      pos_d   = slfr_pkg::PosW'(ptr_q);
      last_d  = is_last;
      valid_d = 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      ptr_q   <= '0;
      len_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
    end
  end

  // word tags, no reset
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    last_q <= last_d;
  end

  assign busy_o          = busy_q;
  assign re_o            = issue;
  assign raddr_o         = ptr_q[slfr_pkg::AddrW-1:0];
  assign out_valid_o     = valid_q;
  assign byte_position_o = pos_q;
  assign last_o          = last_q;

endmodule

### rtl/core/sync_length_frame_receiver_unit.sv
// Top level of the sync/length framed byte receiver.
// Depends on slfr_pkg, slfr_parser, slfr_frame_ram and slfr_emitter.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_ready_o  | opcode_i, rx_byte_i
//   out     | output    | out_valid_o/out_ready_i| frame_byte_o, byte_position_o, last_o
//
// Accepted frame bytes are written into the 64-byte frame buffer.
// A completed frame of N bytes is read back as a burst, one word a cycle while
// out_ready_i is high; in_ready_o drops after the completing word and rises
// again once the emitter's busy flag has cleared and the parser is back in StRecv.
// Each output word waits in the buffer's read register until taken.
// Reset clears the parser to hunting; buffer contents are not cleared.
module sync_length_frame_receiver_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [slfr_pkg::ByteW-1:0]  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slfr_pkg::ByteW-1:0]  frame_byte_o,
  output logic [slfr_pkg::PosW-1:0]   byte_position_o,
  output logic                        last_o
);

  slfr_pkg::burst_req_t       burst;
  logic                       emit_busy;
  logic                       we;
  logic [slfr_pkg::AddrW-1:0] waddr;
  logic [slfr_pkg::ByteW-1:0] wdata;
  logic                       re;
  logic [slfr_pkg::AddrW-1:0] raddr;

  slfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .emit_busy_i (emit_busy),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .burst_o     (burst)
  );

  slfr_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (frame_byte_o)
  );

  slfr_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .burst_i         (burst),
    .busy_o          (emit_busy),
    .re_o            (re),
    .raddr_o         (raddr),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_position_o (byte_position_o),
    .last_o          (last_o)
  );

endmodule

### rtl/core/slfr_checker.sv
// Port-level checks for the framed byte receiver, bound to the top level.
// Depends on slfr_pkg for widths and sync codes.
module slfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [slfr_pkg::ByteW-1:0]  frame_byte_o,
  input logic [slfr_pkg::PosW-1:0]   byte_position_o,
  input logic                        last_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o) &&
                                    $stable(byte_position_o) && $stable(last_o))
    else $error("stalled output word changed");

  // a burst runs without gaps and positions count up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && byte_position_o == $past(byte_position_o) + slfr_pkg::PosW'(1))
    else $error("burst position did not advance");

  // every frame opens with the sync pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_position_o == slfr_pkg::PosW'(0) ||
                    byte_position_o == slfr_pkg::PosW'(1)) |->
      (byte_position_o == slfr_pkg::PosW'(0) && frame_byte_o == slfr_pkg::SyncFirst) ||
      (byte_position_o == slfr_pkg::PosW'(1) && frame_byte_o == slfr_pkg::SyncSecond))
    else $error("frame does not start with sync bytes");

  // no input is taken mid-burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready during a burst");

endmodule

bind sync_length_frame_receiver_unit slfr_checker u_slfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .frame_byte_o    (frame_byte_o),
  .byte_position_o (byte_position_o),
  .last_o          (last_o)
);

### bench/sync_length_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for sync_length_frame_receiver_unit: directed and random byte streams, with
// every emitted frame word checked against a behavioural frame parser kept in the bench.
// Depends on slfr_pkg and the RTL of sync_length_frame_receiver_unit.
module sync_length_frame_receiver_unit_tb;

  localparam int CycleLimit = 400000;

  // One emitted frame word
  typedef struct packed {
    logic [slfr_pkg::ByteW-1:0] data;
    logic [slfr_pkg::PosW-1:0]  pos;
    logic                       last;
  } frame_word_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       opcode_i    = slfr_pkg::OpByte;
  logic [slfr_pkg::ByteW-1:0] rx_byte_i   = '0;
  logic                       out_ready_i = 1'b0;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [slfr_pkg::ByteW-1:0] frame_byte_o;
  logic [slfr_pkg::PosW-1:0]  byte_position_o;
  logic                       last_o;

  // Parser shadow state
  logic [slfr_pkg::CountW-1:0] shadow_fill  = '0;
  logic [slfr_pkg::ExpW-1:0]   shadow_total = '0;
  logic [slfr_pkg::ByteW-1:0]  shadow_frame [slfr_pkg::FrameBytes];

  frame_word_t expected_words [$];
  frame_word_t want_word;
  int          err_count  = 0;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  bit          bursty     = 1'b0;

  sync_length_frame_receiver_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_o          (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Cycle count, run limit and the receiver's stall pattern
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    case (cycle_cnt[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 2) != 0);
      2'd2: out_ready_i <= (cycle_cnt % 7 > 2);
      default: out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("sync_length_frame_receiver_unit verification failed");
      $finish;
    end
  end

  // Shadow parser: updates on each accepted input word, queues the frame when complete
  function automatic void predict_frame_words(logic op, logic [slfr_pkg::ByteW-1:0] b);
    int k;
    if (op == slfr_pkg::OpReset) begin
      shadow_fill  = '0;
      shadow_total = '0;
      return;
    end
    if (shadow_fill == 0 && b != slfr_pkg::SyncFirst) return;
    // bad second byte restarts the hunt and is itself dropped
    if (shadow_fill == 1 && b != slfr_pkg::SyncSecond) begin
      shadow_fill  = '0;
      shadow_total = '0;
      return;
    end
    shadow_frame[shadow_fill[slfr_pkg::AddrW-1:0]] = b;
    shadow_fill = shadow_fill + 1'b1;
    if (shadow_fill == slfr_pkg::HeaderLen)
      shadow_total = {1'b0, shadow_frame[2]} + slfr_pkg::HeaderLen;
    if (shadow_total != 0 && shadow_fill >= shadow_total) begin
      for (k = 0; k < shadow_fill; k++)
        expected_words.push_back('{shadow_frame[k], slfr_pkg::PosW'(k),
                                   k == shadow_fill - 1});
      shadow_fill  = '0;
      shadow_total = '0;
      return;
    end
    // buffer full without completion: frame dropped silently
    if (shadow_fill >= slfr_pkg::FrameBytes) begin
      shadow_fill  = '0;
      shadow_total = '0;
    end
  endfunction

  // Output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %h pos %0d last %0b",
                 $time, frame_byte_o, byte_position_o, last_o);
        err_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (frame_byte_o !== want_word.data || byte_position_o !== want_word.pos ||
            last_o !== want_word.last) begin
          $display("%0t: word mismatch: expected byte %h pos %0d last %0b, got %h %0d %0b",
                   $time, want_word.data, want_word.pos, want_word.last,
                   frame_byte_o, byte_position_o, last_o);
          err_count++;
        end
      end
    end
  end

  // Sends one word; called at a rising edge, returns at the edge it was taken (or after a gap)
  task automatic send_word(input logic op, input logic [slfr_pkg::ByteW-1:0] b);
    int gap;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame_words(op, b);
    if (bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Holds the sender off until every queued word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic send_frame(input int len_field, input int payload_n);
    int k;
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
    send_word(slfr_pkg::OpByte, slfr_pkg::ByteW'(len_field));
    for (k = 0; k < payload_n; k++)
      send_word(slfr_pkg::OpByte, slfr_pkg::ByteW'($urandom_range(0, 255)));
  endtask

  // Noise while hunting, including a reset word carrying the first sync byte
  task automatic test_hunt_noise();
    send_word(slfr_pkg::OpByte, 8'h00);
    send_word(slfr_pkg::OpByte, 8'hFF);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
    send_word(slfr_pkg::OpReset, slfr_pkg::SyncFirst);
  endtask

  // Shortest frame: header only
  task automatic test_min_frame();
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
    send_word(slfr_pkg::OpByte, 8'h00);
  endtask

  // Second byte wrong, also when it is the first sync byte again
  task automatic test_bad_second();
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, 8'h00);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
    send_word(slfr_pkg::OpByte, 8'h01);
    send_word(slfr_pkg::OpByte, 8'hFF);
  endtask

  // Reset word mid-frame, then a good frame
  task automatic test_reset_opcode();
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
    send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
    send_word(slfr_pkg::OpByte, 8'h05);
    send_word(slfr_pkg::OpByte, 8'h11);
    send_word(slfr_pkg::OpReset, 8'hFF);
    send_frame(1, 1);
  endtask

  // Full-size frame completes; one that declares one byte more is dropped at the buffer limit
  task automatic test_buffer_limits();
    bursty = 1'b0;
    send_frame(slfr_pkg::FrameBytes - 3, slfr_pkg::FrameBytes - 3);
    bursty = 1'b1;
    send_frame(slfr_pkg::FrameBytes - 2, slfr_pkg::FrameBytes - 3);
    send_frame(0, 0);
  endtask

  // Mostly well-formed frames with random content, plus broken sequences and noise
  task automatic test_random_traffic();
    int sent;
    int kind;
    int len;
    int k;
    logic [slfr_pkg::ByteW-1:0] b;
    sent = 0;
    while (sent < 40) begin
      bursty = ($urandom_range(0, 3) != 0);
      kind   = $urandom_range(0, 19);
      if (kind < 13) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, slfr_pkg::FrameBytes - 3)
                                            : $urandom_range(0, 10);
        send_frame(len, len);
        sent += len + 3;
      end else if (kind < 15) begin
        b = slfr_pkg::ByteW'($urandom_range(0, 255));
        if (b == slfr_pkg::SyncSecond) b = slfr_pkg::SyncFirst;
        send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
        send_word(slfr_pkg::OpByte, b);
        sent += 2;
      end else if (kind < 17) begin
        len = $urandom_range(1, 12);
        send_word(slfr_pkg::OpByte, slfr_pkg::SyncFirst);
        send_word(slfr_pkg::OpByte, slfr_pkg::SyncSecond);
        send_word(slfr_pkg::OpByte, slfr_pkg::ByteW'(len));
        for (k = 0; k < $urandom_range(0, len - 1); k++)
          send_word(slfr_pkg::OpByte, slfr_pkg::ByteW'($urandom_range(0, 255)));
        send_word(slfr_pkg::OpReset, slfr_pkg::ByteW'($urandom_range(0, 255)));
        sent += 4;
      end else if (kind == 17) begin
        wait_drained();
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(logic'($urandom_range(0, 1)), slfr_pkg::ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hunt_noise();
    test_min_frame();
    test_bad_second();
    test_reset_opcode();
    wait_drained();
    test_buffer_limits();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_count == 0)
      $display("sync_length_frame_receiver_unit verification clean");
    else
      $display("sync_length_frame_receiver_unit verification failed");
    $finish;
  end

endmodule
